### src/commodity_channel_index_top_macros.svh
// Assertion macros used by the RTL
`ifndef COMMODITY_CHANNEL_INDEX_TOP_MACROS_SVH
`define COMMODITY_CHANNEL_INDEX_TOP_MACROS_SVH

// same-cycle implication
`define CCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cci assertion failed");

// next-cycle implication
`define CCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cci assertion failed");

`endif

### src/cci_pkg.sv
`timescale 1ns / 1ps
package cci_pkg;
    localparam int DEF_MAX_PERIOD = 32;
    localparam int DEF_PRICE_BITS = 32;
    localparam int PERIOD_W       = 6;
    localparam int TOL_W          = 16;
    localparam int CCI_W          = 32;
    localparam int TOL_SHIFT      = 32;
    localparam int RESET_PERIOD   = 14;
    // 1000 * 65536: 1/0.015 scaling and Q16.16
    localparam int KC             = 65536000;
    localparam int KC_W           = 26;

    localparam logic REG_PERIOD   = 1'b0;
    localparam logic REG_FLAT_TOL = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage

### src/cci_ram.sv
`timescale 1ns / 1ps
module cci_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/cci_muldiv.sv
`timescale 1ns / 1ps
// floor(num * mult / (15 * dev)), one add/compare step per cycle, num < 15 * dev
module cci_muldiv #(
    parameter int A_W = 40,
    parameter int D_W = 46,
    parameter int K_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_num,
    input  logic [K_W-1:0]     i_mult,
    input  logic [D_W-1:0]     i_dev,
    output cci_pkg::t_div_stat o_stat,
    output logic [K_W-1:0]     o_quot
);
    import cci_pkg::*;

    localparam int B_W = D_W + 4;
    localparam int R_W = B_W + 1;
    localparam int C_W = $clog2(K_W + 1);

    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [K_W-1:0] r_k;
    logic [R_W-1:0] r_r;
    logic [K_W-1:0] r_q;
    logic [C_W-1:0] r_cnt;
    logic           r_ph;
    logic           r_busy;
    logic           r_done;

    logic [R_W-1:0] w_base;
    logic [R_W-1:0] w_add;
    logic [R_W-1:0] w_t;
    logic           w_ge;
    logic [R_W-1:0] w_nr;
    logic [K_W-1:0] w_nq;

    always_comb begin
        w_base = r_ph ? r_r : {r_r[R_W-2:0], 1'b0};
        w_add  = (r_ph && r_k[K_W-1]) ? R_W'(r_a) : '0;
        w_t    = w_base + w_add;
        w_ge   = (w_t >= R_W'(r_b));
        w_nr   = w_ge ? (w_t - R_W'(r_b)) : w_t;
        w_nq   = (r_ph ? r_q : {r_q[K_W-2:0], 1'b0}) + K_W'(w_ge);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_num;
                r_b    <= (B_W'(i_dev) << 4) - B_W'(i_dev);
                r_k    <= i_mult;
                r_r    <= '0;
                r_q    <= '0;
                r_cnt  <= C_W'(K_W);
                r_ph   <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r  <= w_nr;
                r_q  <= w_nq;
                r_ph <= ~r_ph;
                if (r_ph) begin
                    r_k   <= {r_k[K_W-2:0], 1'b0};
                    r_cnt <= r_cnt - C_W'(1);
                    if (r_cnt == C_W'(1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;
endmodule

### src/commodity_channel_index_top.sv
`timescale 1ns / 1ps
// Commodity channel index engine. One price bar per input item; once the window
// holds N bars (N = period register, clamped to 2..MAX_PERIOD), each bar yields
// one item: signed Q16.16 CCI in tdata and the flat flag in tuser. The input is
// not ready while a bar is in work. A bar that yields a result makes two passes
// over the window memory, one entry a cycle through its single read port, then
// goes through the bit-serial multiply-divide unit, one multiplier bit at a time.
// A flat window skips the divide. A warm-up bar returns to idle after the check.
`include "commodity_channel_index_top_macros.svh"
module commodity_channel_index_top #(
    parameter int MAX_PERIOD = cci_pkg::DEF_MAX_PERIOD,
    parameter int PRICE_BITS = cci_pkg::DEF_PRICE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // high_price, low_price, close_price
    input  logic [((3*PRICE_BITS+7)/8)*8-1:0]     i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // cci_value
    output logic [cci_pkg::CCI_W-1:0]             o_m_tdata,
    // flat_window
    output logic                                  o_m_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import cci_pkg::*;

    localparam int AW  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int NW  = $clog2(MAX_PERIOD + 1);
    localparam int XW  = PRICE_BITS + 2;
    localparam int SW  = XW + NW;
    localparam int DW  = SW + NW;
    localparam int KW  = NW + KC_W;
    localparam int TLW = TOL_W + SW;
    localparam int TNW = TLW + NW;
    localparam int FW1 = SW + TOL_SHIFT;
    localparam int FW2 = DW + TOL_SHIFT;
    localparam int QX  = (KW > 33) ? KW : 33;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_SUM, ST_DEV, ST_NUM, ST_TOL, ST_FLAT, ST_DIV, ST_DONE
    } t_state;

    t_state          r_state;
    logic [PERIOD_W-1:0] r_period;
    logic [TOL_W-1:0] r_tol_cfg;
    logic [XW-1:0]   r_x;
    logic [AW-1:0]   r_wp;
    logic [NW-1:0]   r_fill;
    logic [NW-1:0]   r_n;
    logic [AW-1:0]   r_addr;
    logic [NW-1:0]   r_iss;
    logic            r_rvld;
    logic [SW-1:0]   r_nx;
    logic            r_nxv;
    logic [SW-1:0]   r_acc_s;
    logic [DW-1:0]   r_acc_d;
    logic [SW-1:0]   r_num;
    logic            r_neg;
    logic [TLW-1:0]  r_tolv;
    logic [TNW-1:0]  r_toln;
    logic [KW-1:0]   r_k;
    logic            r_flat;
    logic [CCI_W-1:0] r_res;
    logic            r_ovld;
    logic [CCI_W-1:0] r_odata;
    logic            r_oflat;

    logic            w_accept;
    logic [XW-1:0]   w_x;
    logic [NW-1:0]   w_p;
    logic [XW-1:0]   w_rdata;
    logic [SW-1:0]   w_prod;
    logic [SW-1:0]   w_diff;
    logic [SW-1:0]   w_nxx;
    logic            w_flat;
    logic            w_issue;
    logic            w_div_start;
    t_div_stat       w_div_stat;
    logic [KW-1:0]   w_quot;
    logic [QX-1:0]   w_qx;
    logic [CCI_W-1:0] w_sat;

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(MAX_PERIOD - 1) : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == AW'(MAX_PERIOD - 1)) ? '0 : a + AW'(1);
    endfunction

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_x = XW'(i_s_tdata[PRICE_BITS-1:0]) + XW'(i_s_tdata[2*PRICE_BITS-1:PRICE_BITS])
               + XW'(i_s_tdata[3*PRICE_BITS-1:2*PRICE_BITS]);

    always_comb begin
        if (r_period < PERIOD_W'(2)) begin
            w_p = NW'(2);
        end else if (32'(r_period) > 32'(MAX_PERIOD)) begin
            w_p = NW'(MAX_PERIOD);
        end else begin
            w_p = NW'(r_period);
        end
    end

    assign w_issue = (r_state == ST_SUM || r_state == ST_DEV) && (r_iss != r_n);
    assign w_prod  = SW'(r_n) * SW'(w_rdata);
    assign w_diff  = (r_nx >= r_acc_s) ? (r_nx - r_acc_s) : (r_acc_s - r_nx);
    assign w_nxx   = SW'(r_n) * SW'(r_x);
    assign w_flat  = (r_acc_d == '0)
                   || ({r_num, {TOL_SHIFT{1'b0}}} <= FW1'(r_tolv))
                   || ({r_acc_d, {TOL_SHIFT{1'b0}}} <= FW2'(r_toln));
    assign w_div_start = (r_state == ST_FLAT) && !w_flat;

    assign w_qx = QX'(w_quot);
    always_comb begin
        if (r_neg) begin
            w_sat = (w_qx > QX'(33'h080000000)) ? 32'h80000000 : (32'd0 - w_qx[31:0]);
        end else begin
            w_sat = (w_qx > QX'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : w_qx[31:0];
        end
    end

    cci_ram #(.WIDTH(XW), .DEPTH(MAX_PERIOD)) u_window (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wp),
        .i_wdata (w_x),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    cci_muldiv #(.A_W(SW), .D_W(DW), .K_W(KW)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_mult  (r_k),
        .i_dev   (r_acc_d),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_period  <= PERIOD_W'(RESET_PERIOD);
            r_tol_cfg <= '0;
            r_wp      <= '0;
            r_fill    <= '0;
            r_rvld    <= 1'b0;
            r_nxv     <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_PERIOD) begin
                    r_period <= pwdata[PERIOD_W-1:0];
                end else begin
                    r_tol_cfg <= pwdata[TOL_W-1:0];
                end
            end
            if (r_ovld && i_m_tready && r_state != ST_DONE) begin
                r_ovld <= 1'b0;
            end

            r_rvld <= w_issue;
            if (w_issue) begin
                r_addr <= f_dec(r_addr);
                r_iss  <= r_iss + NW'(1);
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_x  <= w_x;
                        r_wp <= f_inc(r_wp);
                        if (r_fill != NW'(MAX_PERIOD)) begin
                            r_fill <= r_fill + NW'(1);
                        end
                        r_n     <= w_p;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (r_fill < r_n) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr  <= f_dec(r_wp);
                        r_iss   <= '0;
                        r_acc_s <= '0;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (r_rvld) begin
                        r_acc_s <= r_acc_s + SW'(w_rdata);
                    end
                    if (!w_issue && !r_rvld) begin
                        r_addr  <= f_dec(r_wp);
                        r_iss   <= '0;
                        r_acc_d <= '0;
                        r_state <= ST_DEV;
                    end
                end
                ST_DEV: begin
                    r_nxv <= r_rvld;
                    if (r_rvld) begin
                        r_nx <= w_prod;
                    end
                    if (r_nxv) begin
                        r_acc_d <= r_acc_d + DW'(w_diff);
                    end
                    if (!w_issue && !r_rvld && !r_nxv) begin
                        r_state <= ST_NUM;
                    end
                end
                ST_NUM: begin
                    r_neg   <= (w_nxx < r_acc_s);
                    r_num   <= (w_nxx < r_acc_s) ? (r_acc_s - w_nxx) : (w_nxx - r_acc_s);
                    r_tolv  <= TLW'(r_tol_cfg) * TLW'(r_acc_s);
                    r_k     <= KW'(r_n) * KW'(KC);
                    r_state <= ST_TOL;
                end
                ST_TOL: begin
                    r_toln  <= TNW'(r_tolv) * TNW'(r_n);
                    r_state <= ST_FLAT;
                end
                ST_FLAT: begin
                    r_flat <= w_flat;
                    if (w_flat) begin
                        r_res   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_stat.done) begin
                        r_res   <= w_sat;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_ovld || i_m_tready) begin
                        r_ovld  <= 1'b1;
                        r_odata <= r_res;
                        r_oflat <= r_flat;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_oflat;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_FLAT_TOL) ? 32'(r_tol_cfg) : 32'(r_period);

    `CCI_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_tready)
    `CCI_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= NW'(MAX_PERIOD))
    `CCI_ASSERT_IMP(a_div_start, i_clk, i_rst_n, w_div_start, !w_div_stat.busy && r_acc_d != '0)
    `CCI_ASSERT_IMP(a_flat_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == '0)
endmodule

### dv/tb_commodity_channel_index_top.sv
`timescale 1ns / 1ps
module tb_commodity_channel_index_top;
    import cci_pkg::*;

    localparam int NWIN = 32;
    localparam int IDLE_PCT = 14;
    localparam int WDOG_LIMIT = 20000;
    localparam logic [2:0] ADDR_PERIOD = 3'd0;
    localparam logic [2:0] ADDR_FLAT_TOL = 3'd4;

    typedef struct packed {
        logic [31:0] cci;
        logic        flat;
    } t_cci_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    commodity_channel_index_top uut (.*);

    // predictor state
    logic [33:0] tp_window [NWIN];
    int unsigned tp_wptr;
    int unsigned tp_fill;
    logic [5:0]  cfg_period;
    logic [15:0] cfg_tol;

    t_cci_result expected_q[$];
    bit          failed;
    bit          no_idle;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] k,
                                                    logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            q = q << 1;
            r = r << 1;
            if (r >= b) begin
                r = r - b;
                q = q + 1;
            end
            if (k[bit_i]) begin
                r = r + a;
                if (r >= b) begin
                    r = r - b;
                    q = q + 1;
                end
            end
        end
        return q;
    endfunction

    task automatic predict_cci(input logic [31:0] hi, input logic [31:0] lo,
                               input logic [31:0] cl);
        logic [63:0] x, n, s, nx, num, d, tol, cci;
        int unsigned p, idx;
        bit neg, flat;
        t_cci_result res;
        x = 64'(hi) + 64'(lo) + 64'(cl);
        tp_window[tp_wptr] = x[33:0];
        tp_wptr = (tp_wptr + 1) % NWIN;
        if (tp_fill < NWIN) tp_fill++;
        p = 32'(cfg_period);
        if (p < 2) p = 2;
        if (p > NWIN) p = NWIN;
        if (tp_fill < p) return;
        n = 64'(p);
        s = 0;
        for (int k = 0; k < p; k++) begin
            idx = (tp_wptr + NWIN - 1 - k) % NWIN;
            s += 64'(tp_window[idx]);
        end
        d = 0;
        for (int k = 0; k < p; k++) begin
            idx = (tp_wptr + NWIN - 1 - k) % NWIN;
            nx = n * 64'(tp_window[idx]);
            d += (nx >= s) ? (nx - s) : (s - nx);
        end
        nx = n * x;
        neg = nx < s;
        num = neg ? (s - nx) : (nx - s);
        tol = 64'(cfg_tol) * s;
        flat = (d == 0) || (num <= (tol >> 32)) || (d <= ((tol * n) >> 32));
        if (flat) begin
            res.cci = '0;
            res.flat = 1'b1;
        end else begin
            cci = scaled_quotient(num, n * 64'(KC), 64'd15 * d);
            if (neg) begin
                if (cci > 64'h8000_0000) cci = 64'h8000_0000;
                res.cci = 32'(64'd0 - cci);
            end else begin
                if (cci > 64'h7FFF_FFFF) cci = 64'h7FFF_FFFF;
                res.cci = cci[31:0];
            end
            res.flat = 1'b0;
        end
        expected_q.push_back(res);
    endtask

    // tvalid stays high between back-to-back items; idle gaps and drain() drop it
    task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo,
                            input logic [31:0] cl);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {cl, lo, hi};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_cci(hi, lo, cl);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_PERIOD) cfg_period = val[5:0];
        else cfg_tol = val[15:0];
    endtask

    function automatic logic [31:0] rand_price();
        case ($urandom_range(4))
            0: return 32'hFFFF_FFFF - $urandom_range(3);
            1: return $urandom_range(3);
            2: return 32'd1000 + $urandom_range(20);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        for (int i = 0; i < 16; i++) send_bar(32'd100 + i, 32'd90, 32'd95 + (i % 3));
        drain();
    endtask

    task automatic test_field_extremes();
        write_reg(ADDR_PERIOD, 32'd2);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'd0, 32'd0, 32'd0);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_F0F0);
        send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'hF0F0_0F0F);
        drain();
    endtask

    task automatic test_period_clamp();
        write_reg(ADDR_PERIOD, 32'd0);
        for (int i = 0; i < 3; i++) send_bar(rand_price(), rand_price(), rand_price());
        drain();
        write_reg(ADDR_PERIOD, 32'd63);
        for (int i = 0; i < 34; i++) send_bar(rand_price(), rand_price(), rand_price());
        drain();
        write_reg(ADDR_PERIOD, 32'd1);
        send_bar(32'd5, 32'd5, 32'd5);
        drain();
    endtask

    task automatic test_flat_tolerance();
        write_reg(ADDR_PERIOD, 32'd4);
        write_reg(ADDR_FLAT_TOL, 32'hFFFF);
        for (int i = 0; i < 8; i++) send_bar(32'd1000000 + i, 32'd1000000, 32'd1000000);
        drain();
        write_reg(ADDR_FLAT_TOL, 32'd0);
        for (int i = 0; i < 6; i++) send_bar(32'd7, 32'd7, 32'd7);
        drain();
    endtask

    task automatic test_random_bars();
        int unsigned periods [4] = '{2, 5, 14, 32};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(ADDR_PERIOD, (ph == 7) ? $urandom_range(63) : periods[ph % 4]);
            write_reg(ADDR_FLAT_TOL, (ph % 3 == 0) ? 32'd0 : $urandom_range(65535));
            no_idle = (ph == 4);
            for (int i = 0; i < 150; i++) begin
                if ($urandom_range(3) == 0)
                    send_bar(rand_price(), rand_price(), rand_price());
                else
                    send_bar(32'd50000 + $urandom_range(4000), 32'd48000 + $urandom_range(4000),
                             32'd49000 + $urandom_range(4000));
            end
            drain();
        end
        no_idle = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_cci_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result cci=%h flat=%b", $time, o_m_tdata, o_m_tuser);
                failed = 1'b1;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_m_tdata !== exp_r.cci) begin
                    $display("%0t cci expected %h actual %h", $time, exp_r.cci, o_m_tdata);
                    failed = 1'b1;
                end
                if (o_m_tuser !== exp_r.flat) begin
                    $display("%0t flat expected %b actual %b", $time, exp_r.flat, o_m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        failed = 1'b0;
        no_idle = 1'b0;
        quiet_cycles = 0;
        tp_wptr = 0;
        tp_fill = 0;
        cfg_period = 6'(RESET_PERIOD);
        cfg_tol = '0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_field_extremes();
        test_period_clamp();
        test_flat_tolerance();
        test_random_bars();
        if (!failed && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
